[sv/rmts_pkg.sv]
package rmts_pkg;

    // Four task slots of configuration are always stored.
    localparam int unsigned SLOTS       = 4;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned REG_W       = 8;
    localparam int unsigned TIME_W      = 16;
    localparam int unsigned TASK_W      = 2;

    // The low bit of a register index selects the kind of register in a slot.
    localparam logic REG_KIND_WCET   = 1'b0;
    localparam logic REG_KIND_PERIOD = 1'b1;

    localparam logic [REG_W-1:0] WCET_RESET   = 8'd0;
    localparam logic [REG_W-1:0] PERIOD_RESET = 8'd1;

    typedef struct packed {
        logic [REG_W-1:0] wcet;
        logic [REG_W-1:0] period;
    } t_task_cfg;

    typedef t_task_cfg [SLOTS-1:0] t_cfg_arr;

    typedef struct packed {
        logic              overrun;
        logic              idle;
        logic [TASK_W-1:0] running_task;
        logic [TIME_W-1:0] time_now;
    } t_result;

    // A period of zero behaves as a period of one.
    function automatic logic [REG_W-1:0] eff_period(input logic [REG_W-1:0] p);
        eff_period = (p == '0) ? REG_W'(1) : p;
    endfunction

endpackage

[sv/rmts_cfg.sv]
module rmts_cfg
    import rmts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_wdata,
    output t_cfg_arr             o_cfg
);

    t_cfg_arr r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_cfg[s].wcet   <= WCET_RESET;
                r_cfg[s].period <= PERIOD_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx[0] == REG_KIND_WCET) begin
                r_cfg[i_cfg_idx[CFG_IDX_W-1:1]].wcet <= i_cfg_wdata;
            end else begin
                r_cfg[i_cfg_idx[CFG_IDX_W-1:1]].period <= i_cfg_wdata;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/rmts_core.sv]
module rmts_core
    import rmts_pkg::*;
#(
    parameter int unsigned TASK_COUNT = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_cfg_arr i_cfg,
    output t_result  o_res
);

    logic [REG_W-1:0]  r_rem   [TASK_COUNT];
    logic [REG_W-1:0]  r_phase [TASK_COUNT];
    logic [TIME_W-1:0] r_time;

    logic [REG_W-1:0]  n_rem   [TASK_COUNT];
    logic [REG_W-1:0]  n_phase [TASK_COUNT];
    logic [REG_W-1:0]  rel_rem [TASK_COUNT];
    logic              over;
    logic              found;
    logic [TASK_W-1:0] best;
    logic [REG_W-1:0]  best_per;

    always_comb begin
        over     = 1'b0;
        found    = 1'b0;
        best     = '0;
        best_per = '0;
        // Release: a task whose countdown has reached zero reloads its work.
        for (int t = 0; t < TASK_COUNT; t++) begin
            if (r_phase[t] == '0) begin
                if (r_rem[t] != '0) begin
                    over = 1'b1;
                end
                rel_rem[t] = i_cfg[t].wcet;
                n_phase[t] = eff_period(i_cfg[t].period) - REG_W'(1);
            end else begin
                rel_rem[t] = r_rem[t];
                n_phase[t] = r_phase[t] - REG_W'(1);
            end
        end
        // Strict less-than keeps ties at the lower index.
        for (int t = 0; t < TASK_COUNT; t++) begin
            if (rel_rem[t] != '0 &&
                (!found || eff_period(i_cfg[t].period) < best_per)) begin
                found    = 1'b1;
                best     = TASK_W'(t);
                best_per = eff_period(i_cfg[t].period);
            end
        end
        for (int t = 0; t < TASK_COUNT; t++) begin
            if (found && best == TASK_W'(t)) begin
                n_rem[t] = rel_rem[t] - REG_W'(1);
            end else begin
                n_rem[t] = rel_rem[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TASK_COUNT; t++) begin
                r_rem[t]   <= '0;
                r_phase[t] <= '0;
            end
            r_time <= '0;
        end else if (i_step) begin
            for (int t = 0; t < TASK_COUNT; t++) begin
                r_rem[t]   <= n_rem[t];
                r_phase[t] <= n_phase[t];
            end
            r_time <= r_time + TIME_W'(1);
        end
    end

    assign o_res.time_now     = r_time;
    assign o_res.running_task = best;
    assign o_res.idle         = !found;
    assign o_res.overrun      = over;

endmodule

[sv/rate_monotonic_tick_scheduler_top.sv]
// A tick beat accepted at one edge shows its result beat in the cycle after that edge.
// One beat per cycle while the result sink keeps up; release, priority pick and work update are one pass
// of logic between the task state registers and the result register.
// A beat with tick low is taken and gives no result.
// Reset (synchronous, active low) clears task state, time and the result valid flag,
// and loads every wcet with 0 and every period with 1.
module rate_monotonic_tick_scheduler_top
    import rmts_pkg::*;
#(
    parameter int unsigned TASK_COUNT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,  // [0] tick
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [15:0] time_now, [17:16] running_task, [18] idle, [19] overrun
    output logic [23:0]          o_m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_wdata
);

    t_cfg_arr cfg;
    t_result  res;
    t_result  r_res;
    logic     r_out_valid;
    logic     in_acc;
    logic     step;

    rmts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rmts_core #(
        .TASK_COUNT (TASK_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // The result register frees up in the same cycle its beat is taken.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign step            = in_acc && i_s_axis_tdata[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_res};

    a_tick_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_m_axis_tvalid)
        else $error("accepted tick did not produce a result beat");

    a_idle_task_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[18]) |-> (o_m_axis_tdata[17:16] == 2'd0))
        else $error("idle result names a nonzero task");

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while result register is empty");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

[tb/rate_monotonic_tick_scheduler_top_tb.sv]
`timescale 1ns / 100ps

module rate_monotonic_tick_scheduler_top_tb;
    import rmts_pkg::*;

    localparam int unsigned TASKS       = 4;
    localparam int unsigned REG_COUNT   = 2 * SLOTS;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned MAX_PRINTS  = 40;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [REG_W-1:0]     cfg_wdata = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [23:0]          o_m_axis_tdata;

    // Predicted scheduler state and the programmed task table.
    logic [REG_W-1:0]  task_wcet [SLOTS];
    logic [REG_W-1:0]  task_period [SLOTS];
    logic [REG_W-1:0]  work_left [SLOTS];
    logic [REG_W-1:0]  ticks_to_release [SLOTS];
    logic [TIME_W-1:0] tick_count;
    t_result           pending_decisions [$];

    int unsigned mismatches   = 0;
    bit          src_gaps     = 1'b0;
    bit          sink_gaps    = 1'b0;
    bit          hold_request = 1'b0;

    always #10 i_clk = ~i_clk;

    rate_monotonic_tick_scheduler_top #(
        .TASK_COUNT(TASKS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    task automatic note_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("%0t: %s got %0d expected %0d", $time, what, got_v, want_v);
        end
    endtask

    // One scheduling decision: releases first, then the shortest period with
    // work left runs for this tick.
    function automatic void decide_tick();
        logic [REG_W-1:0] p;
        logic [REG_W-1:0] best_period;
        int               best;
        t_result          d;
        d           = '0;
        best        = -1;
        best_period = '0;
        d.time_now  = tick_count;
        for (int t = 0; t < TASKS; t++) begin
            p = (task_period[t] == '0) ? 8'd1 : task_period[t];
            if (ticks_to_release[t] == '0) begin
                if (work_left[t] != '0) begin
                    d.overrun = 1'b1;
                end
                work_left[t]        = task_wcet[t];
                ticks_to_release[t] = p - 8'd1;
            end else begin
                ticks_to_release[t] = ticks_to_release[t] - 8'd1;
            end
        end
        for (int t = 0; t < TASKS; t++) begin
            p = (task_period[t] == '0) ? 8'd1 : task_period[t];
            if (work_left[t] != '0 && (best < 0 || p < best_period)) begin
                best        = t;
                best_period = p;
            end
        end
        if (best < 0) begin
            d.idle = 1'b1;
        end else begin
            d.running_task  = best[TASK_W-1:0];
            work_left[best] = work_left[best] - 8'd1;
        end
        pending_decisions.insert(pending_decisions.size(), d);
        tick_count = tick_count + 1'b1;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (cfg_we) begin
                if (cfg_idx[0] == REG_KIND_WCET) begin
                    task_wcet[cfg_idx >> 1] = cfg_wdata;
                end else begin
                    task_period[cfg_idx >> 1] = cfg_wdata;
                end
            end
            // Results leave only after the tick that made them is accepted, so pop before push.
            if (o_m_axis_tvalid && m_tready) begin
                got = o_m_axis_tdata[$bits(t_result)-1:0];
                if (pending_decisions.size() == 0) begin
                    note_mismatch("unexpected result beat, time_now", got.time_now, 0);
                end else begin
                    want = pending_decisions.pop_front();
                    if (got.time_now != want.time_now) begin
                        note_mismatch("time_now", got.time_now, want.time_now);
                    end
                    if (got.running_task != want.running_task) begin
                        note_mismatch("running_task", got.running_task, want.running_task);
                    end
                    if (got.idle != want.idle) begin
                        note_mismatch("idle", got.idle, want.idle);
                    end
                    if (got.overrun != want.overrun) begin
                        note_mismatch("overrun", got.overrun, want.overrun);
                    end
                end
            end
            if (s_tvalid && o_s_axis_tready && s_tdata[0]) begin
                decide_tick();
            end
        end
    end

    initial begin : sink
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Offers one beat and returns at the edge that takes it; tvalid stays high.
    task automatic send_beat(input logic tick_bit);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{7{1'b0}}, tick_bit};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Stops offering beats and waits until every decision has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Slot s of each argument sits at bits [8*s +: 8].
    task automatic program_tasks(input logic [SLOTS*REG_W-1:0] wcets,
                                 input logic [SLOTS*REG_W-1:0] periods);
        for (int r = 0; r < REG_COUNT; r++) begin
            cfg_we  <= 1'b1;
            cfg_idx <= r[CFG_IDX_W-1:0];
            if (r[0] == REG_KIND_WCET) begin
                cfg_wdata <= wcets[(r / 2) * REG_W +: REG_W];
            end else begin
                cfg_wdata <= periods[(r / 2) * REG_W +: REG_W];
            end
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SLOTS*REG_W-1:0] random_wcets();
        logic [SLOTS*REG_W-1:0] v;
        for (int s = 0; s < SLOTS; s++) begin
            case ($urandom_range(0, 9))
                0:       v[s*REG_W +: REG_W] = 8'd0;
                1:       v[s*REG_W +: REG_W] = 8'd255;
                2, 3:    v[s*REG_W +: REG_W] = 8'd1;
                4:       v[s*REG_W +: REG_W] = REG_W'($urandom_range(0, 255));
                default: v[s*REG_W +: REG_W] = REG_W'($urandom_range(2, 5));
            endcase
        end
        return v;
    endfunction

    function automatic logic [SLOTS*REG_W-1:0] random_periods();
        logic [SLOTS*REG_W-1:0] v;
        for (int s = 0; s < SLOTS; s++) begin
            case ($urandom_range(0, 9))
                0:       v[s*REG_W +: REG_W] = 8'd0;
                1:       v[s*REG_W +: REG_W] = 8'd255;
                2:       v[s*REG_W +: REG_W] = 8'd1;
                3:       v[s*REG_W +: REG_W] = REG_W'($urandom_range(0, 255));
                default: v[s*REG_W +: REG_W] = REG_W'($urandom_range(2, 12));
            endcase
        end
        return v;
    endfunction

    // Out of reset every task is disabled, so every tick is idle.
    task automatic test_reset_state();
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b1);
        settle();
    endtask

    task automatic test_directed_schedules();
        // Long job at period one overruns at each release after its first; a zero period acts as one
        // and ties with task 0, which wins on index.
        program_tasks({8'd0, 8'd2, 8'd1, 8'd255}, {8'd255, 8'd4, 8'd0, 8'd1});
        for (int i = 0; i < 5; i++) send_beat(1'b1);
        settle();
        // Tasks 1 and 2 share a period; task 3 has the shortest one.
        program_tasks({8'd1, 8'd3, 8'd3, 8'd0}, {8'd2, 8'd5, 8'd5, 8'd9});
        for (int i = 0; i < 8; i++) send_beat(1'b1);
        settle();
        // All disabled: leftover work found at a release still counts as overrun.
        program_tasks({8'd0, 8'd0, 8'd0, 8'd0}, {8'd1, 8'd1, 8'd1, 8'd1});
        for (int i = 0; i < 4; i++) send_beat(1'b1);
        settle();
    endtask

    task automatic test_random_schedules(input int phases);
        int n;
        for (int ph = 0; ph < phases; ph++) begin
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            program_tasks(random_wcets(), random_periods());
            n = $urandom_range(80, 160);
            for (int i = 0; i < n; i++) begin
                send_beat($urandom_range(0, 9) != 0);
            end
            settle();
        end
    endtask

    // The sink holds off while ticks keep coming, so the input has to stall.
    task automatic test_output_backpressure();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        program_tasks(random_wcets(), random_periods());
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) send_beat(1'b1);
        settle();
    endtask

    // Ends the run with back-to-back beats and no idling on either side.
    task automatic test_back_to_back();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        program_tasks(random_wcets(), random_periods());
        for (int i = 0; i < 100; i++) send_beat(1'b1);
        settle();
    endtask

    initial begin : run
        for (int s = 0; s < SLOTS; s++) begin
            task_wcet[s]        = WCET_RESET;
            task_period[s]      = PERIOD_RESET;
            work_left[s]        = '0;
            ticks_to_release[s] = '0;
        end
        tick_count = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_schedules();
        test_random_schedules(14);
        test_output_backpressure();
        test_back_to_back();
        if (mismatches == 0 && pending_decisions.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
